/* rtl/core/clom_pkg.sv */
// Shared types and constants for the circular log offset mapper.
// No dependencies; clom_ctrl, clom_dp and the top level refer to this package.
`timescale 1ns / 1ps

package clom_pkg;

    // Field and register widths
    localparam int SEQ_W        = 64;
    localparam int OFF_W        = 33;
    localparam int FB_W         = 32;
    localparam int FC_W         = 7;
    localparam int CAP_W        = FB_W + FC_W;
    localparam int STEP_W       = 7;
    localparam int RING_W       = 32;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 32;
    localparam int S_TDATA_W    = 64;
    localparam int M_TDATA_W    = 40;

    // Defaults
    localparam int unsigned HEADER_BYTES_DEF = 2048;
    localparam int unsigned START_LSN_DEF    = 8192;
    localparam logic [FB_W-1:0] FILE_BYTES_RST = 32'd16777216;
    localparam logic [FC_W-1:0] FILE_COUNT_RST = 7'd2;

    // Register indexes on the configuration channel
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FILE_BYTES = 2'd0,
        CFG_FILE_COUNT = 2'd1
    } cfg_index_t;

    // Operation selected for the shared divider
    typedef enum logic [1:0] {
        DIV_BASE_FILE = 2'd0,   // base_offset / file_bytes
        DIV_BASE_RING = 2'd1,   // stripped base % capacity
        DIV_DIST      = 2'd2,   // |seq - base_seq| % capacity
        DIV_RING_FILE = 2'd3    // ring / usable
    } div_op_t;

    typedef struct packed {
        logic    load;
        logic    cap_en;
        logic    div_start;
        div_op_t div_op;
        logic    keep_mod;
        logic    strip_en;
        logic    dist_en;
        logic    ring_en;
        logic    real_en;
        logic    finish;
    } dp_cmd_t;

    typedef struct packed {
        logic cap_zero;
        logic div_done;
        logic out_free;
    } dp_status_t;

endpackage

/* rtl/core/clom_div.sv */
// Serial restoring divider, one quotient bit per cycle.
// Depends on nothing; instantiated by clom_dp.
`timescale 1ns / 1ps

module clom_div #(
    parameter int DVD_W = 64,
    parameter int DSR_W = 39,
    parameter int CNT_W = 7
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,   // left aligned, top 'steps' bits used
    input  logic [DSR_W-1:0] divisor,
    input  logic [CNT_W-1:0] steps,
    output logic             done,
    output logic [DVD_W-1:0] quotient,   // quotient in the low 'steps' bits
    output logic [DSR_W-1:0] remainder
);

    logic [DVD_W-1:0] dvd_reg;
    logic [DSR_W-1:0] dsr_reg;
    logic [DSR_W-1:0] rem_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             run_reg;
    logic             done_reg;

    logic [DSR_W:0]   rem_shift;
    logic [DSR_W:0]   rem_sub;
    logic             take;

    always_comb begin
        rem_shift = {rem_reg, dvd_reg[DVD_W-1]};
        rem_sub   = rem_shift - {1'b0, dsr_reg};
        take      = (rem_shift >= {1'b0, dsr_reg});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                run_reg <= 1'b1;
                cnt_reg <= steps;
            end else if (run_reg) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg <= dividend;
            dsr_reg <= divisor;
            rem_reg <= '0;
        end else if (run_reg) begin
            dvd_reg <= {dvd_reg[DVD_W-2:0], take};
            rem_reg <= take ? rem_sub[DSR_W-1:0] : rem_shift[DSR_W-1:0];
        end
    end

    assign done      = done_reg;
    assign quotient  = dvd_reg;
    assign remainder = rem_reg;

endmodule

/* rtl/core/clom_ctrl.sv */
// Sequencer of the offset mapper: steps the datapath through its phases.
// Depends on clom_pkg (command and status structs).
`timescale 1ns / 1ps

module clom_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  clom_pkg::dp_status_t status,
    output clom_pkg::dp_cmd_t    cmd
);

    typedef enum logic [15:0] {
        ST_IDLE    = 16'h0001,
        ST_CAP     = 16'h0002,
        ST_D1_GO   = 16'h0004,
        ST_D1_WAIT = 16'h0008,
        ST_STRIP   = 16'h0010,
        ST_D2_GO   = 16'h0020,
        ST_D2_WAIT = 16'h0040,
        ST_D3_GO   = 16'h0080,
        ST_D3_WAIT = 16'h0100,
        ST_DIST    = 16'h0200,
        ST_RING    = 16'h0400,
        ST_D4_GO   = 16'h0800,
        ST_D4_WAIT = 16'h1000,
        ST_REAL    = 16'h2000,
        ST_DONE    = 16'h4000,
        ST_SPARE   = 16'h8000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.div_op = clom_pkg::DIV_BASE_FILE;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_CAP;
                end
            end
            ST_CAP: begin
                cmd.cap_en = 1'b1;
                state_next = ST_D1_GO;
            end
            ST_D1_GO: begin
                // zero capacity: skip all arithmetic, report an error
                if (status.cap_zero) begin
                    state_next = ST_DONE;
                end else begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_D1_WAIT;
                end
            end
            ST_D1_WAIT: begin
                if (status.div_done) state_next = ST_STRIP;
            end
            ST_STRIP: begin
                cmd.strip_en = 1'b1;
                state_next   = ST_D2_GO;
            end
            ST_D2_GO: begin
                cmd.div_start = 1'b1;
                cmd.div_op    = clom_pkg::DIV_BASE_RING;
                state_next    = ST_D2_WAIT;
            end
            ST_D2_WAIT: begin
                if (status.div_done) state_next = ST_D3_GO;
            end
            ST_D3_GO: begin
                cmd.keep_mod  = 1'b1;
                cmd.div_start = 1'b1;
                cmd.div_op    = clom_pkg::DIV_DIST;
                state_next    = ST_D3_WAIT;
            end
            ST_D3_WAIT: begin
                if (status.div_done) state_next = ST_DIST;
            end
            ST_DIST: begin
                cmd.dist_en = 1'b1;
                state_next  = ST_RING;
            end
            ST_RING: begin
                cmd.ring_en = 1'b1;
                state_next  = ST_D4_GO;
            end
            ST_D4_GO: begin
                cmd.div_start = 1'b1;
                cmd.div_op    = clom_pkg::DIV_RING_FILE;
                state_next    = ST_D4_WAIT;
            end
            ST_D4_WAIT: begin
                if (status.div_done) state_next = ST_REAL;
            end
            ST_REAL: begin
                cmd.real_en = 1'b1;
                state_next  = ST_DONE;
            end
            ST_DONE: begin
                // hold until the output register can take the result
                if (status.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

endmodule

/* rtl/core/clom_dp.sv */
// Datapath of the offset mapper: config and base registers, shared divider,
// intermediate results and the output register.
// Depends on clom_pkg and clom_div.
`timescale 1ns / 1ps

module clom_dp #(
    parameter int unsigned HEADER_BYTES = clom_pkg::HEADER_BYTES_DEF,
    parameter int unsigned START_LSN    = clom_pkg::START_LSN_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    input  logic [clom_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [clom_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              in_mode,
    input  logic [clom_pkg::SEQ_W-1:0]        in_seq,
    input  clom_pkg::dp_cmd_t                 cmd,
    output clom_pkg::dp_status_t              status,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [clom_pkg::OFF_W-1:0]        m_offset,
    output logic                              m_error
);

    localparam int SEQ_W   = clom_pkg::SEQ_W;
    localparam int OFF_W   = clom_pkg::OFF_W;
    localparam int FB_W    = clom_pkg::FB_W;
    localparam int FC_W    = clom_pkg::FC_W;
    localparam int CAP_W   = clom_pkg::CAP_W;
    localparam int RING_W  = clom_pkg::RING_W;
    localparam int STEP_W  = clom_pkg::STEP_W;
    localparam int HDR_W   = $clog2(HEADER_BYTES + 1);
    localparam int STRIP_W = OFF_W + 1 + HDR_W;
    localparam int REAL_W  = RING_W + 2 + HDR_W;

    // Configuration and base pair
    logic [FB_W-1:0]  file_bytes_reg;
    logic [FC_W-1:0]  file_count_reg;
    logic [SEQ_W-1:0] base_seq_reg;
    logic [OFF_W-1:0] base_offset_reg;

    // Per-item working registers
    logic             mode_reg;
    logic [SEQ_W-1:0] seq_reg;
    logic             fwd_reg;
    logic [SEQ_W-1:0] diff_reg;
    logic [FB_W-1:0]  usable_reg;
    logic [CAP_W-1:0] cap_reg;
    logic [OFF_W-1:0] base_ring_reg;
    logic [CAP_W-1:0] base_mod_reg;
    logic [CAP_W-1:0] dist_reg;
    logic [CAP_W-1:0] ring_reg;
    logic             ring_err_reg;
    logic [REAL_W-1:0] real_reg;

    // Output register
    logic             m_valid_reg;
    logic [OFF_W-1:0] m_offset_reg;
    logic             m_error_reg;

    // Divider hookup
    logic [SEQ_W-1:0]  div_dvd;
    logic [CAP_W-1:0]  div_dsr;
    logic [STEP_W-1:0] div_steps;
    logic              div_done;
    logic [SEQ_W-1:0]  div_quot;
    logic [CAP_W-1:0]  div_rem;

    logic [STRIP_W-1:0] strip;
    logic [STRIP_W-1:0] base_ext;
    logic [CAP_W:0]     ring_sum;
    logic [CAP_W:0]     ring_wrap;
    logic [CAP_W-1:0]   ring_next;
    logic [REAL_W-1:0]  hdr_total;
    logic               real_err;
    logic               item_err;

    always_comb begin
        case (cmd.div_op)
            clom_pkg::DIV_BASE_FILE: begin
                div_dvd   = {base_offset_reg, {(SEQ_W-OFF_W){1'b0}}};
                div_dsr   = CAP_W'(file_bytes_reg);
                div_steps = STEP_W'(OFF_W);
            end
            clom_pkg::DIV_BASE_RING: begin
                div_dvd   = {base_ring_reg, {(SEQ_W-OFF_W){1'b0}}};
                div_dsr   = cap_reg;
                div_steps = STEP_W'(OFF_W);
            end
            clom_pkg::DIV_DIST: begin
                div_dvd   = diff_reg;
                div_dsr   = cap_reg;
                div_steps = STEP_W'(SEQ_W);
            end
            clom_pkg::DIV_RING_FILE: begin
                div_dvd   = {ring_reg[RING_W-1:0], {(SEQ_W-RING_W){1'b0}}};
                div_dsr   = CAP_W'(usable_reg);
                div_steps = STEP_W'(RING_W);
            end
            default: begin
                div_dvd   = diff_reg;
                div_dsr   = cap_reg;
                div_steps = STEP_W'(SEQ_W);
            end
        endcase
    end

    clom_div #(
        .DVD_W (SEQ_W),
        .DSR_W (CAP_W),
        .CNT_W (STEP_W)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.div_start),
        .dividend  (div_dvd),
        .divisor   (div_dsr),
        .steps     (div_steps),
        .done      (div_done),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    always_comb begin
        // headers ahead of the base: HEADER_BYTES * (1 + base_offset / file_bytes)
        strip    = (STRIP_W'(div_quot[OFF_W-1:0]) + STRIP_W'(1)) * STRIP_W'(HEADER_BYTES);
        base_ext = STRIP_W'(base_offset_reg);
        ring_sum  = (CAP_W+1)'(base_mod_reg) + (CAP_W+1)'(dist_reg);
        ring_wrap = ring_sum - (CAP_W+1)'(cap_reg);
        ring_next = (ring_sum >= (CAP_W+1)'(cap_reg)) ? ring_wrap[CAP_W-1:0]
                                                      : ring_sum[CAP_W-1:0];
        hdr_total = (REAL_W'(div_quot[RING_W-1:0]) + REAL_W'(1)) * REAL_W'(HEADER_BYTES);
        real_err  = |real_reg[REAL_W-1:OFF_W];
        item_err  = (cap_reg == '0) || ring_err_reg || real_err;
    end

    // Configuration writes and base pair
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            file_bytes_reg  <= clom_pkg::FILE_BYTES_RST;
            file_count_reg  <= clom_pkg::FILE_COUNT_RST;
            base_seq_reg    <= SEQ_W'(START_LSN);
            base_offset_reg <= OFF_W'(HEADER_BYTES);
        end else begin
            if (cfg_valid && cfg_index == clom_pkg::CFG_FILE_BYTES) begin
                file_bytes_reg <= cfg_data[FB_W-1:0];
            end
            if (cfg_valid && cfg_index == clom_pkg::CFG_FILE_COUNT) begin
                file_count_reg <= cfg_data[FC_W-1:0];
            end
            if (cmd.finish && mode_reg && !item_err) begin
                base_seq_reg    <= seq_reg;
                base_offset_reg <= real_reg[OFF_W-1:0];
            end
        end
    end

    // Working registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            mode_reg   <= in_mode;
            seq_reg    <= in_seq;
            fwd_reg    <= (in_seq >= base_seq_reg);
            diff_reg   <= (in_seq >= base_seq_reg) ? in_seq - base_seq_reg
                                                   : base_seq_reg - in_seq;
            usable_reg <= (file_bytes_reg > FB_W'(HEADER_BYTES))
                        ? file_bytes_reg - FB_W'(HEADER_BYTES) : '0;
        end
        if (cmd.cap_en) begin
            cap_reg <= CAP_W'(usable_reg) * CAP_W'(file_count_reg);
        end
        if (cmd.strip_en) begin
            base_ring_reg <= (base_ext > strip) ? OFF_W'(base_ext - strip) : '0;
        end
        if (cmd.keep_mod) begin
            base_mod_reg <= div_rem;
        end
        if (cmd.dist_en) begin
            // backward distance wraps around the ring
            if (fwd_reg || div_rem == '0) begin
                dist_reg <= fwd_reg ? div_rem : '0;
            end else begin
                dist_reg <= cap_reg - div_rem;
            end
        end
        if (cmd.ring_en) begin
            ring_reg     <= ring_next;
            ring_err_reg <= |ring_next[CAP_W-1:RING_W];
        end
        if (cmd.real_en) begin
            real_reg <= REAL_W'(ring_reg[RING_W-1:0]) + hdr_total;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.finish) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            m_offset_reg <= item_err ? '0 : real_reg[OFF_W-1:0];
            m_error_reg  <= item_err;
        end
    end

    assign status.cap_zero = (cap_reg == '0);
    assign status.div_done = div_done;
    assign status.out_free = !m_valid_reg || m_tready;

    assign m_tvalid = m_valid_reg;
    assign m_offset = m_offset_reg;
    assign m_error  = m_error_reg;

endmodule

/* rtl/core/circular_log_offset_mapper.sv */
// Top level of the circular log offset mapper: ports, controller, datapath.
// Depends on clom_pkg, clom_ctrl and clom_dp (which holds clom_div).
`timescale 1ns / 1ps
//
//  Channel  Direction  Handshake          Payload
//  -------  ---------  -----------------  --------------------------------------
//  s_       in         s_tvalid/s_tready  tdata: seq_number; tuser: mode
//  m_       out        m_tvalid/m_tready  tdata: real_offset; tuser: range_error
//  cfg_     in         cfg_valid/ready    cfg_index: register, cfg_data: value
//
//  Each request is taken only after the previous one has finished: one shared
//  radix-2 divider runs 33 + 33 + 64 + 32 steps (base/file size, base %
//  capacity, distance % capacity, ring/usable), and the controller waits for
//  its done pulse after each run. With zero capacity the request skips the
//  divisions and finishes with range_error set.
//  Reset (aresetn low, synchronous) restores file_bytes, file_count and the
//  base pair. A finished result sits in the output register, so the next
//  request is taken while m_tready stalls; the block stalls only when a
//  second result is ready and the first has not been taken.

module circular_log_offset_mapper #(
    parameter int unsigned HEADER_BYTES = clom_pkg::HEADER_BYTES_DEF,
    parameter int unsigned START_LSN    = clom_pkg::START_LSN_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // Request channel
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [clom_pkg::S_TDATA_W-1:0]   s_tdata,   // [63:0] seq_number
    input  logic [0:0]                       s_tuser,   // [0] mode
    // Result channel
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [clom_pkg::M_TDATA_W-1:0]   m_tdata,   // [32:0] real_offset, rest zero
    output logic [0:0]                       m_tuser,   // [0] range_error
    // Configuration write channel
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [clom_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [clom_pkg::CFG_DATA_W-1:0]  cfg_data
);

    clom_pkg::dp_cmd_t    cmd;
    clom_pkg::dp_status_t status;

    logic [clom_pkg::OFF_W-1:0] offset;
    logic                       error;

    // The user must write configuration only while idle; the block does not enforce this and takes every write at once.
    assign cfg_ready = 1'b1;

    clom_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    clom_dp #(
        .HEADER_BYTES (HEADER_BYTES),
        .START_LSN    (START_LSN)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_mode   (s_tuser[0]),
        .in_seq    (s_tdata),
        .cmd       (cmd),
        .status    (status),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_offset  (offset),
        .m_error   (error)
    );

    // Pad the offset up to whole bytes.
    assign m_tdata = {{(clom_pkg::M_TDATA_W-clom_pkg::OFF_W){1'b0}}, offset};
    assign m_tuser = error;

endmodule
